// File: rtl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types, status codes and mod-11 helpers for the ID check digit
// validator.
// ----------------------------------------------------------------------------
package cpf_pkg;

  // String layout: nine body digits, a hyphen, two check digits
  localparam logic [3:0] HYPHEN_IDX       = 4'd9;
  localparam logic [3:0] FIRST_CHECK_IDX  = 4'd10;
  localparam logic [3:0] SECOND_CHECK_IDX = 4'd11;
  localparam logic [3:0] ID_LEN           = 4'd12;
  localparam logic [3:0] POS_MAX          = 4'd15;

  localparam logic [7:0] ASCII_ZERO   = 8'd48;
  localparam logic [7:0] ASCII_NINE   = 8'd57;
  localparam logic [7:0] ASCII_HYPHEN = 8'd45;

  localparam logic [3:0] MODULUS       = 4'd11;
  localparam logic [3:0] FIRST_W_BASE  = 4'd10;
  localparam logic [3:0] SECOND_W_BASE = 4'd11;
  localparam logic [3:0] CHECK1_W      = 4'd2;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ST_TOO_LONG  = 3'd2;
  localparam logic [2:0] ST_TOO_SHORT = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic       id_valid;
    logic [2:0] status;
  } out_t;

  // x mod 11 for x < 128: quotient by reciprocal multiply (187 / 2048)
  function automatic logic [3:0] mod11(input logic [6:0] x);
    logic [14:0] prod;
    logic [3:0]  quo;
    logic [6:0]  rem;
    prod = 15'(x) * 15'd187;
    quo  = prod[14:11];
    rem  = x - (7'(quo) * 7'(MODULUS));
    return rem[3:0];
  endfunction

  // Check digit from a residue mod 11
  function automatic logic [3:0] check_digit(input logic [3:0] res);
    return (res < 4'd2) ? 4'd0 : (MODULUS - res);
  endfunction

endpackage

// File: rtl/cpf_acc.sv
// ----------------------------------------------------------------------------
// cpf_acc
// Per-string accumulator: position, format flag, two weighted digit sums
// kept as residues mod 11, and the end-of-string verdict.
// ----------------------------------------------------------------------------
module cpf_acc (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          take,
  input  cpf_pkg::in_t  item,
  output logic          res_fire,
  output cpf_pkg::out_t res_data
);

  logic [3:0] pos_r, pos_nxt;
  logic       bad_r, bad_nxt;
  logic [3:0] rem1_r, rem1_nxt;
  logic [3:0] rem2_r, rem2_nxt;
  logic [3:0] chk1_r, chk1_nxt;

  logic       is_digit;
  logic [3:0] dig;
  logic [3:0] w1;
  logic [3:0] w2;
  logic [6:0] acc1;
  logic [6:0] acc2;
  logic [2:0] status;

  assign is_digit = (item.char_code >= cpf_pkg::ASCII_ZERO) &&
                    (item.char_code <= cpf_pkg::ASCII_NINE);
  assign dig      = is_digit ? 4'(item.char_code - cpf_pkg::ASCII_ZERO) : 4'd0;
  assign w1       = cpf_pkg::FIRST_W_BASE - pos_r;
  assign w2       = cpf_pkg::SECOND_W_BASE - pos_r;
  assign acc1     = 7'(rem1_r) + (7'(w1) * 7'(dig));
  assign acc2     = 7'(rem2_r) + (7'(w2) * 7'(dig));

  always_comb begin
    pos_nxt  = (pos_r < cpf_pkg::POS_MAX) ? pos_r + 4'd1 : pos_r;
    bad_nxt  = bad_r;
    rem1_nxt = rem1_r;
    rem2_nxt = rem2_r;
    chk1_nxt = chk1_r;
    if (pos_r == cpf_pkg::HYPHEN_IDX) begin
      if (item.char_code != cpf_pkg::ASCII_HYPHEN) bad_nxt = 1'b1;
    end else if (!is_digit) begin
      bad_nxt = 1'b1;
    end else if (pos_r < cpf_pkg::HYPHEN_IDX) begin
      rem1_nxt = cpf_pkg::mod11(acc1);
      rem2_nxt = cpf_pkg::mod11(acc2);
    end else if (pos_r == cpf_pkg::FIRST_CHECK_IDX) begin
      chk1_nxt = dig;
      rem2_nxt = cpf_pkg::mod11(7'(rem2_r) + (7'(cpf_pkg::CHECK1_W) * 7'(dig)));
    end
  end

  // Sums are final before the second check digit arrives
  always_comb begin
    if (bad_nxt) begin
      status = cpf_pkg::ST_BAD_CHAR;
    end else if (pos_r >= cpf_pkg::ID_LEN) begin
      status = cpf_pkg::ST_TOO_LONG;
    end else if (pos_r < cpf_pkg::SECOND_CHECK_IDX) begin
      status = cpf_pkg::ST_TOO_SHORT;
    end else if ((cpf_pkg::check_digit(rem1_r) != chk1_r) ||
                 (cpf_pkg::check_digit(rem2_r) != dig)) begin
      status = cpf_pkg::ST_MISMATCH;
    end else begin
      status = cpf_pkg::ST_OK;
    end
  end

  assign res_fire          = take && item.last_char;
  assign res_data.status   = status;
  assign res_data.id_valid = (status == cpf_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n || res_fire) begin
      pos_r  <= 4'd0;
      bad_r  <= 1'b0;
      rem1_r <= 4'd0;
      rem2_r <= 4'd0;
      chk1_r <= 4'd0;
    end else if (take) begin
      pos_r  <= pos_nxt;
      bad_r  <= bad_nxt;
      rem1_r <= rem1_nxt;
      rem2_r <= rem2_nxt;
      chk1_r <= chk1_nxt;
    end
  end

endmodule

// File: rtl/cpf_check_digit_validator.sv
// ----------------------------------------------------------------------------
// cpf_check_digit_validator
// Streams an ID string one character per transaction and reports whether
// its format, length and two mod-11 check digits are correct.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle, with last_char marking the
// end of the string. Each body digit updates two weighted sums, held as
// residues mod 11 so each step is one small multiply-add and a constant
// reduction. The verdict is formed in the same cycle as the last character
// and lands in the output register, so out_valid is set in the cycle after the
// last character is accepted; characters that are not last produce no
// result. The output register is the only buffer: in_stall follows
// out_stall while a result is pending, and otherwise the block keeps one
// character per cycle, also back to back across strings. After each result
// all per-string state clears for the next string.
module cpf_check_digit_validator (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cpf_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cpf_pkg::out_t out_data
);

  logic          out_valid_r;
  cpf_pkg::out_t out_data_r;
  logic          take;
  logic          res_fire;
  cpf_pkg::out_t res_data;

  // Hold input while a finished result waits on a stalled output
  assign in_stall = out_valid_r && out_stall;
  assign take     = in_valid && !in_stall;

  cpf_acc u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .item     (in_data),
    .res_fire (res_fire),
    .res_data (res_data)
  );

  // Advance the output register whenever it is empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && res_fire) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A result only follows an accepted last character
  a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && !in_stall && in_data.last_char))
    else $error("result without a last character");

  // id_valid agrees with status
  a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.id_valid == (out_data_r.status == cpf_pkg::ST_OK)))
    else $error("id_valid disagrees with status");

  // Status is always a defined code
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status <= cpf_pkg::ST_MISMATCH))
    else $error("undefined status code");

  // Accepted last character always produces a result next cycle
  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_char) |=> out_valid_r)
    else $error("last character produced no result");

endmodule
